/* hdl/bqe_pkg.sv */
// ----------------------------------------------------------------------------
// bqe_pkg: shared types and constants of the bit-quad euler/perimeter block
// widths, class codes, register indexes and saturating helpers
// ----------------------------------------------------------------------------
package bqe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W = 11;                    // config register width
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int IDX_W = 4;                     // config index width

  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
  localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);

  localparam int CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int SUM_W  = CNT_W + 2;            // q1 + q3 + 2*qd
  localparam int COEF_W = 32;
  localparam int PROD_W = SUM_W + COEF_W;
  localparam int E4_W   = 24;                   // wide signed before saturation
  localparam int OUT_SW = 22;
  localparam int PER_W  = 29;
  localparam int DIAG_W = PROD_W + 1 - 24;
  localparam int PSUM_W = DIAG_W + 1;

  // 1/sqrt(2) as a 0.32 fraction
  localparam logic [COEF_W-1:0] INV_SQRT2_Q32 = 32'd3037000500;
  localparam logic [PROD_W:0]   ROUND_HALF    = (PROD_W+1)'(1) << 23;

  localparam logic [PER_W-1:0]   PER_MAX = {PER_W{1'b1}};
  localparam logic signed [E4_W-1:0] S22_MAX = E4_W'(2097151);
  localparam logic signed [E4_W-1:0] S22_MIN = -E4_W'(2097152);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // window classes
  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_NONE  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_THREE = 3'd1;  // three background pixels
  localparam logic [CLS_W-1:0] CLS_ONE   = 3'd2;  // one background pixel
  localparam logic [CLS_W-1:0] CLS_DIAG  = 3'd3;  // diagonal pair
  localparam logic [CLS_W-1:0] CLS_EDGE  = 3'd4;  // other two-background

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic             area;
    logic             last;
  } quad_entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                               input logic en);
    if (en && v != CNT_MAX) return v + CNT_W'(1);
    return v;
  endfunction

  function automatic logic [OUT_SW-1:0] sat22(input logic signed [E4_W-1:0] v);
    if (v > S22_MAX) return OUT_SW'(S22_MAX);
    if (v < S22_MIN) return OUT_SW'(S22_MIN);
    return v[OUT_SW-1:0];
  endfunction

endpackage

/* hdl/bqe_front.sv */
// ----------------------------------------------------------------------------
// bqe_front: pixel intake, line buffer and window classification
// keeps the previous row and emits one class record per accepted pixel
// ----------------------------------------------------------------------------
module bqe_front import bqe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_region,
  input  logic              queue_full,
  output logic              push,
  output quad_entry_t       push_entry,
  output logic              restart
);

  logic [DIM_W-1:0] width_reg, height_reg;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             left_px, ul_px;
  logic             above_q;
  logic             row_mem [MAX_WIDTH];
  logic [COL_W-1:0] rd_addr;
  logic             col_last, row_last, win;
  logic [2:0]       ones;

  assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                              cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DIM_RESET;
      height_reg <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
        REG_IMAGE_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_reg;
    if (width_reg < DIM_MIN) w_eff = DIM_MIN;
    else if (width_reg > WIDTH_MAX) w_eff = WIDTH_MAX;
    h_eff = height_reg;
    if (height_reg < DIM_MIN) h_eff = DIM_MIN;
    else if (height_reg > HEIGHT_MAX) h_eff = HEIGHT_MAX;
  end

  assign push     = in_valid && !queue_full;
  assign col_last = ({1'b0, col} + DIM_W'(1)) >= w_eff;
  assign row_last = ({1'b0, row} + DIM_W'(1)) >= h_eff;
  assign win      = (row != '0) && (col != '0);
  assign ones     = 3'(ul_px) + 3'(above_q) + 3'(left_px) + 3'(in_region);

  always_comb begin
    push_entry.cls = CLS_NONE;
    if (win) begin
      case (ones)
        3'd1: push_entry.cls = CLS_THREE;
        3'd2: push_entry.cls = (ul_px == in_region) ? CLS_DIAG : CLS_EDGE;
        3'd3: push_entry.cls = CLS_ONE;
        default: push_entry.cls = CLS_NONE;
      endcase
    end
    push_entry.area = win && ul_px;
    push_entry.last = col_last && row_last;
  end

  // read one column ahead so the registered line data is ready on arrival
  always_comb begin
    if (rst || restart) rd_addr = '0;
    else if (push) rd_addr = col_last ? '0 : col + COL_W'(1);
    else rd_addr = col;
  end

  always_ff @(posedge clk) begin
    above_q <= row_mem[rd_addr];
    if (push) row_mem[col] <= in_region;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col     <= '0;
      row     <= '0;
      left_px <= 1'b0;
      ul_px   <= 1'b0;
    end else if (push) begin
      if (col_last) begin
        col     <= '0;
        left_px <= 1'b0;
        ul_px   <= 1'b0;
        row     <= row_last ? '0 : row + ROW_W'(1);
      end else begin
        col     <= col + COL_W'(1);
        left_px <= in_region;
        ul_px   <= above_q;
      end
    end
  end

endmodule

/* hdl/bqe_queue.sv */
// ----------------------------------------------------------------------------
// bqe_queue: short queue of class records between front and back
// ----------------------------------------------------------------------------
module bqe_queue import bqe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  quad_entry_t  push_entry,
  input  logic         pop,
  output quad_entry_t  head,
  output logic         empty,
  output logic         full
);

  quad_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* hdl/bqe_back.sv */
// ----------------------------------------------------------------------------
// bqe_back: quad counters and end-of-frame result pipeline
// accumulates class records, then forms euler, holes and perimeter
// ----------------------------------------------------------------------------
module bqe_back import bqe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 restart,
  input  quad_entry_t          head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_W-1:0]     quad_three_bg,
  output logic [CNT_W-1:0]     quad_one_bg,
  output logic [CNT_W-1:0]     quad_diagonal,
  output logic [CNT_W-1:0]     quad_edge,
  output logic [CNT_W-1:0]     region_area,
  output logic [OUT_SW-1:0]    euler_times_four,
  output logic [OUT_SW-1:0]    holes_times_four,
  output logic [PER_W-1:0]     perimeter_fixed
);

  logic [CNT_W-1:0] cnt_three, cnt_one, cnt_diag, cnt_edge, cnt_area;
  logic [CNT_W-1:0] n_three, n_one, n_diag, n_edge, n_area;
  logic             res_busy;

  // stage 1: frame totals
  logic             s1_valid;
  logic [CNT_W-1:0] s1_three, s1_one, s1_diag, s1_edge, s1_area;
  // stage 2: product and signed results
  logic              s2_valid;
  logic [CNT_W-1:0]  s2_three, s2_one, s2_diag, s2_edge, s2_area;
  logic [PROD_W-1:0] s2_prod;
  logic [OUT_SW-1:0] s2_e4, s2_h4;

  logic [SUM_W-1:0]         sum_w;
  logic signed [E4_W-1:0]   e4_w, h4_w;
  logic [PROD_W:0]          rounded;
  logic [DIAG_W-1:0]        diag_w;
  logic [PSUM_W-1:0]        per_w;

  assign res_busy = s1_valid || s2_valid || out_valid;
  assign pop      = !empty && (!head.last || !res_busy);

  assign n_three = sat_inc(cnt_three, head.cls == CLS_THREE);
  assign n_one   = sat_inc(cnt_one,   head.cls == CLS_ONE);
  assign n_diag  = sat_inc(cnt_diag,  head.cls == CLS_DIAG);
  assign n_edge  = sat_inc(cnt_edge,  head.cls == CLS_EDGE);
  assign n_area  = sat_inc(cnt_area,  head.area);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      cnt_three <= '0;
      cnt_one   <= '0;
      cnt_diag  <= '0;
      cnt_edge  <= '0;
      cnt_area  <= '0;
    end else if (pop) begin
      if (head.last) begin
        cnt_three <= '0;
        cnt_one   <= '0;
        cnt_diag  <= '0;
        cnt_edge  <= '0;
        cnt_area  <= '0;
      end else begin
        cnt_three <= n_three;
        cnt_one   <= n_one;
        cnt_diag  <= n_diag;
        cnt_edge  <= n_edge;
        cnt_area  <= n_area;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      s1_three <= n_three;
      s1_one   <= n_one;
      s1_diag  <= n_diag;
      s1_edge  <= n_edge;
      s1_area  <= n_area;
    end
  end

  assign sum_w = SUM_W'(s1_three) + SUM_W'(s1_one) + {1'b0, s1_diag, 1'b0};
  assign e4_w  = $signed(E4_W'(s1_three)) - $signed(E4_W'(s1_one))
               + $signed(E4_W'({s1_diag, 1'b0}));
  assign h4_w  = E4_W'(4) - e4_w;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_three <= s1_three;
      s2_one   <= s1_one;
      s2_diag  <= s1_diag;
      s2_edge  <= s1_edge;
      s2_area  <= s1_area;
      s2_prod  <= PROD_W'(sum_w) * PROD_W'(INV_SQRT2_Q32);
      s2_e4    <= sat22(e4_w);
      s2_h4    <= sat22(h4_w);
    end
  end

  // round half up, keep integer part plus 8 fraction bits
  assign rounded = {1'b0, s2_prod} + ROUND_HALF;
  assign diag_w  = rounded[PROD_W:24];
  assign per_w   = PSUM_W'({s2_edge, 8'b0}) + PSUM_W'(diag_w);

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      quad_three_bg    <= s2_three;
      quad_one_bg      <= s2_one;
      quad_diagonal    <= s2_diag;
      quad_edge        <= s2_edge;
      region_area      <= s2_area;
      euler_times_four <= s2_e4;
      holes_times_four <= s2_h4;
      perimeter_fixed  <= (per_w > PSUM_W'(PER_MAX)) ? PER_MAX : per_w[PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= pop && head.last;
      s2_valid <= s1_valid;
      if (s2_valid) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $onehot0({s1_valid, s2_valid, out_valid}))
    else $error("more than one frame result in flight");

  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid ##1 out_valid)
    else $error("frame result dropped between stages");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    pop && head.last |=> cnt_three == '0 && cnt_one == '0 && cnt_diag == '0
                         && cnt_edge == '0 && cnt_area == '0)
    else $error("counters not cleared after frame end");
`endif

endmodule

/* hdl/bit_quad_euler_perimeter.sv */
// ----------------------------------------------------------------------------
// bit_quad_euler_perimeter: bit-quad euler number and perimeter of a mask
// raster pixel stream in, one statistics item out per frame
// ----------------------------------------------------------------------------
// usage:
//   in channel: one mask bit per item (in_region), raster order, row 0 first
//   out channel: one item on each frame's last pixel with the four quad
//     counts, area, 4*euler, 4*holes and perimeter (8 fraction bits)
//   cfg port: cfg_we/cfg_index/cfg_data, index 0 image_width, 1 image_height;
//     a write to either restarts the frame, other indexes are ignored
// throughput: one pixel per cycle while in_stall is low, set by the registered
//   line buffer read and the counter update; a frame's last pixel waits in the
//   queue until the result path holds no earlier result
// result: the last pixel's record passes the queue, then the totals,
//   multiply and perimeter-sum registers before out_valid rises
// reset: sizes go to 64x64, counters and positions clear; the line buffer
//   holds no reset value and is fully written by row 0 before it is read
// stall: an output stall holds the result; pixels keep flowing into the
//   queue until it fills, then in_stall rises
// ----------------------------------------------------------------------------
module bit_quad_euler_perimeter import bqe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  // pixel channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_region,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CNT_W-1:0]         quad_three_bg,
  output logic [CNT_W-1:0]         quad_one_bg,
  output logic [CNT_W-1:0]         quad_diagonal,
  output logic [CNT_W-1:0]         quad_edge,
  output logic [CNT_W-1:0]         region_area,
  output logic signed [OUT_SW-1:0] euler_times_four,
  output logic signed [OUT_SW-1:0] holes_times_four,
  output logic [PER_W-1:0]         perimeter_fixed
);

  logic        push, pop, q_empty, q_full, restart;
  quad_entry_t push_entry, head;
  logic [OUT_SW-1:0] e4_bits, h4_bits;

  // input stall comes from the queue alone, never from in_valid
  assign in_stall = q_full;

  // front: line buffer and 2x2 window classification
  bqe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_region  (in_region),
    .queue_full (q_full),
    .push       (push),
    .push_entry (push_entry),
    .restart    (restart)
  );

  // class records decouple intake from the counters
  bqe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // back: counting and end-of-frame arithmetic
  bqe_back u_back (
    .clk              (clk),
    .rst              (rst),
    .restart          (restart),
    .head             (head),
    .empty            (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .quad_three_bg    (quad_three_bg),
    .quad_one_bg      (quad_one_bg),
    .quad_diagonal    (quad_diagonal),
    .quad_edge        (quad_edge),
    .region_area      (region_area),
    .euler_times_four (e4_bits),
    .holes_times_four (h4_bits),
    .perimeter_fixed  (perimeter_fixed)
  );

  // signed results in two's complement
  assign euler_times_four = $signed(e4_bits);
  assign holes_times_four = $signed(h4_bits);

endmodule

/* sim/bit_quad_euler_perimeter_tb.sv */
// ----------------------------------------------------------------------------
// bit_quad_euler_perimeter_tb: self-checking bench for the bit-quad block
// streams binary masks in raster order with random idle gaps and output
// stalls, predicts the per-frame quad counts, area, euler, holes and
// perimeter, and compares every result item field by field
// ----------------------------------------------------------------------------
module bit_quad_euler_perimeter_tb;
  import bqe_pkg::*;

  // register indexes the block does not decode
  localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_MID = IDX_W'(8);
  localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(15);

  localparam longint unsigned INV_ROOT2_Q32 = 64'd3037000500;
  localparam longint unsigned PERIM_CEIL = (64'd1 << PER_W) - 1;
  localparam longint SIGNED22_HI = 2097151;
  localparam longint SIGNED22_LO = -2097152;

  // mask fill styles
  typedef enum int {FILL_RANDOM, FILL_CHECKER} fill_style_t;

  localparam int SETTLE_CYCLES = 12;       // pipeline drain before a register write
  localparam int TAIL_CYCLES = 16;         // quiet time after the last result
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_PIXELS = 1500;
  localparam int RANDOM_FRAMES = 10;

  typedef struct {
    logic [CNT_W-1:0]  three_bg;
    logic [CNT_W-1:0]  one_bg;
    logic [CNT_W-1:0]  diag_pair;
    logic [CNT_W-1:0]  side_pair;
    logic [CNT_W-1:0]  area;
    logic [OUT_SW-1:0] euler4;
    logic [OUT_SW-1:0] holes4;
    logic [PER_W-1:0]  perim;
  } frame_stats_t;

  // ---------------------------------------------------------------------------
  // block ports, every input known from time zero
  // ---------------------------------------------------------------------------
  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [DIM_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_region = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CNT_W-1:0]         quad_three_bg;
  logic [CNT_W-1:0]         quad_one_bg;
  logic [CNT_W-1:0]         quad_diagonal;
  logic [CNT_W-1:0]         quad_edge;
  logic [CNT_W-1:0]         region_area;
  logic signed [OUT_SW-1:0] euler_times_four;
  logic signed [OUT_SW-1:0] holes_times_four;
  logic [PER_W-1:0]         perimeter_fixed;

  bit_quad_euler_perimeter i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_region        (in_region),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .quad_three_bg    (quad_three_bg),
    .quad_one_bg      (quad_one_bg),
    .quad_diagonal    (quad_diagonal),
    .quad_edge        (quad_edge),
    .region_area      (region_area),
    .euler_times_four (euler_times_four),
    .holes_times_four (holes_times_four),
    .perimeter_fixed  (perimeter_fixed)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  frame_stats_t stats_pending[$];   // frame totals still owed by the block
  int fail_count = 0;
  int frames_checked = 0;
  int pixels_sent = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;               // sender idling enabled
  bit stalls_on = 1'b1;             // receiver stalling enabled

  // predictor copy of the block: line buffer, window corners, positions,
  // quad counters and the size registers
  bit               row_bits[MAX_WIDTH];
  bit               px_left, px_upleft;
  int unsigned      col_at, row_at;
  bit [CNT_W-1:0]   n_three, n_one, n_diag, n_side, n_area;
  bit [DIM_W-1:0]   width_set, height_set;

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned dim_used(input bit [DIM_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit [CNT_W-1:0] count_up(input bit [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic longint clip22(input longint v);
    if (v > SIGNED22_HI) return SIGNED22_HI;
    if (v < SIGNED22_LO) return SIGNED22_LO;
    return v;
  endfunction

  // window corner registers, positions and counters back to frame start
  function automatic void clear_frame();
    px_left = 1'b0;
    px_upleft = 1'b0;
    col_at = 0;
    row_at = 0;
    n_three = '0;
    n_one = '0;
    n_diag = '0;
    n_side = '0;
    n_area = '0;
  endfunction

  function automatic void reset_predictor();
    foreach (row_bits[i]) row_bits[i] = 1'b0;
    width_set = DIM_W'(64);
    height_set = DIM_W'(64);
    clear_frame();
  endfunction

  function automatic frame_stats_t frame_totals();
    frame_stats_t r;
    longint e4, h4;
    longint unsigned weighted, diag_len, perim;
    e4 = longint'(n_three) - longint'(n_one) + 2 * longint'(n_diag);
    h4 = 4 - e4;
    // three- and one-background quads add 1/sqrt(2) each, diagonal pairs twice that, rounded half up in q.8
    weighted = 64'(n_three) + 64'(n_one) + 2 * 64'(n_diag);
    diag_len = (weighted * INV_ROOT2_Q32 + (64'd1 << 23)) >> 24;
    perim = 64'(n_side) * 256 + diag_len;
    if (perim > PERIM_CEIL) perim = PERIM_CEIL;
    e4 = clip22(e4);
    h4 = clip22(h4);
    r.three_bg = n_three;
    r.one_bg = n_one;
    r.diag_pair = n_diag;
    r.side_pair = n_side;
    r.area = n_area;
    r.euler4 = e4[OUT_SW-1:0];
    r.holes4 = h4[OUT_SW-1:0];
    r.perim = perim[PER_W-1:0];
    return r;
  endfunction

  // one accepted pixel: close the window ending here, advance the raster
  function automatic void predict_pixel(input bit px);
    int unsigned w, h, c, bg;
    bit above, frame_done;
    w = dim_used(width_set, MAX_WIDTH);
    h = dim_used(height_set, MAX_HEIGHT);
    c = (col_at < w) ? col_at : w - 1;
    above = row_bits[c];
    frame_done = 1'b0;
    if (row_at >= 1 && c >= 1) begin
      bg = 4 - (int'(px_upleft) + int'(above) + int'(px_left) + int'(px));
      case (bg)
        3: n_three = count_up(n_three);
        1: n_one = count_up(n_one);
        2: begin
          if (px_upleft == px) n_diag = count_up(n_diag);
          else n_side = count_up(n_side);
        end
        default: ;
      endcase
      if (px_upleft) n_area = count_up(n_area);
    end
    px_upleft = above;
    row_bits[c] = px;
    px_left = px;
    if (c + 1 >= w) begin
      col_at = 0;
      px_left = 1'b0;
      px_upleft = 1'b0;
      if (row_at + 1 >= h) frame_done = 1'b1;
      else row_at++;
    end else begin
      col_at = c + 1;
    end
    if (frame_done) begin
      stats_pending.push_back(frame_totals());
      clear_frame();
    end
  endfunction

  function automatic void predict_write(input logic [IDX_W-1:0] idx,
                                        input logic [DIM_W-1:0] val);
    if (idx == REG_IMAGE_WIDTH) width_set = val;
    else if (idx == REG_IMAGE_HEIGHT) height_set = val;
    else return;
    clear_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    fail_count++;
    $display("mismatch @%0d: %s", cycle_count, what);
  endtask

  function automatic string field_diff(input string name, input logic [63:0] got,
                                       input logic [63:0] want);
    if (got !== want) return $sformatf(" %s=%0h(exp %0h)", name, got, want);
    return "";
  endfunction

  task automatic check_result();
    frame_stats_t want;
    string bad;
    if (stats_pending.size() == 0) begin
      report_mismatch("result item with no frame pending");
      return;
    end
    want = stats_pending.pop_front();
    bad = {field_diff("quad_three_bg", 64'(quad_three_bg), 64'(want.three_bg)),
           field_diff("quad_one_bg", 64'(quad_one_bg), 64'(want.one_bg)),
           field_diff("quad_diagonal", 64'(quad_diagonal), 64'(want.diag_pair)),
           field_diff("quad_edge", 64'(quad_edge), 64'(want.side_pair)),
           field_diff("region_area", 64'(region_area), 64'(want.area)),
           field_diff("euler_times_four", 64'(unsigned'(euler_times_four)),
                      64'(want.euler4)),
           field_diff("holes_times_four", 64'(unsigned'(holes_times_four)),
                      64'(want.holes4)),
           field_diff("perimeter_fixed", 64'(perimeter_fixed), 64'(want.perim))};
    if (bad != "") report_mismatch($sformatf("frame %0d:%s", frames_checked, bad));
    frames_checked++;
  endtask

  // sampled at the edge, so the values seen are those the edge accepts
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
  end

  // ---------------------------------------------------------------------------
  // idle and stall lengths: mostly short, now and then long
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 30);
  endfunction

  // receiver: random stall bursts while enabled
  initial begin
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // valid stays high after acceptance; the next call either reloads it in
  // the same step or drops it before any time passes
  task automatic send_pixel(input bit px);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_region <= px;
    do @(posedge clk); while (in_stall);
    predict_pixel(px);
    pixels_sent++;
  endtask

  // hold the input quiet until every owed result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (stats_pending.size() != 0) @(posedge clk);
  endtask

  // register writes only land on an idle block
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    predict_write(idx, val);
  endtask

  task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // pixel for raster position (r, c) of a frame with the given fill
  function automatic bit mask_pixel(input fill_style_t style, input int pct,
                                    input int r, input int c);
    if (style == FILL_CHECKER) return ((r + c + pct) % 2) != 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  // stream the first count pixels of a frame at the current size
  task automatic send_pixels(input fill_style_t style, input int pct, input int count);
    int w;
    w = dim_used(width_set, MAX_WIDTH);
    for (int i = 0; i < count; i++) send_pixel(mask_pixel(style, pct, i / w, i % w));
  endtask

  task automatic send_frame(input fill_style_t style, input int pct);
    send_pixels(style, pct, dim_used(width_set, MAX_WIDTH) * dim_used(height_set, MAX_HEIGHT));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // width as it comes out of reset: a height write alone, then one 64x2 frame
  task automatic test_reset_size();
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
    send_frame(FILL_RANDOM, 40);
  endtask

  // a 2x2 frame holds exactly one window: walk all sixteen corner patterns
  task automatic test_window_classes();
    set_size(DIM_W'(2), DIM_W'(2));
    for (int p = 0; p < 16; p++) begin
      for (int b = 3; b >= 0; b--) send_pixel(p[b]);
    end
  endtask

  // empty, full and checkerboard masks, the last drives euler hard positive
  task automatic test_solid_and_checker();
    set_size(DIM_W'(5), DIM_W'(5));
    send_frame(FILL_RANDOM, 0);
    send_frame(FILL_RANDOM, 100);
    set_size(DIM_W'(8), DIM_W'(8));
    send_frame(FILL_CHECKER, 0);
    set_size(DIM_W'(9), DIM_W'(7));
    send_frame(FILL_CHECKER, 1);
  endtask

  // smallest sizes, with values below the minimum clamped up
  task automatic test_size_extremes();
    logic [DIM_W-1:0] widths[4] = '{0, 1, 2, 3};
    logic [DIM_W-1:0] heights[4] = '{1, 0, 3, 2};
    for (int i = 0; i < 4; i++) begin
      set_size(widths[i], heights[i]);
      send_frame(FILL_RANDOM, $urandom_range(5, 95));
    end
  endtask

  // a write mid-frame restarts the frame; writes to unused indexes do not
  task automatic test_restart_and_spare_index();
    set_size(DIM_W'(5), DIM_W'(4));
    send_pixels(FILL_RANDOM, 50, 7);
    write_reg(REG_IMAGE_WIDTH, DIM_W'(5));
    send_frame(FILL_RANDOM, 50);
    send_pixels(FILL_RANDOM, 50, 9);
    write_reg(REG_SPARE_LO, DIM_W'(3));
    write_reg(REG_SPARE_MID, DIM_W'(2047));
    write_reg(REG_SPARE_HI, DIM_W'($urandom_range(0, 2047)));
    send_pixels(FILL_RANDOM, 50, 11);
    // height change mid-frame, then a full frame at the new size
    send_pixels(FILL_RANDOM, 50, 6);
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
    send_frame(FILL_RANDOM, 50);
  endtask

  function automatic logic [DIM_W-1:0] random_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return DIM_W'($urandom_range(2, 10));
    if (r < 95) return DIM_W'($urandom_range(11, 24));
    return DIM_W'($urandom_range(0, 1));
  endfunction

  // mostly complete frames back to back with random sizes and fills; some
  // frames are cut short by a size write, some phases run without idling
  task automatic test_random_frames();
    int frames_done, pct, total;
    fill_style_t style;
    frames_done = 0;
    while (pixels_sent < RANDOM_PIXELS || frames_done < RANDOM_FRAMES) begin
      gaps_on = $urandom_range(0, 99) < 70;
      stalls_on = $urandom_range(0, 99) < 70;
      case ($urandom_range(0, 9))
        0, 1: set_size(random_dim(), random_dim());
        2: write_reg(REG_IMAGE_WIDTH, random_dim());
        3: write_reg(REG_IMAGE_HEIGHT, random_dim());
        4: wait_drained();
        default: ;
      endcase
      style = ($urandom_range(0, 9) == 0) ? FILL_CHECKER : FILL_RANDOM;
      case ($urandom_range(0, 5))
        0: pct = 0;
        1: pct = 100;
        default: pct = $urandom_range(10, 90);
      endcase
      total = dim_used(width_set, MAX_WIDTH) * dim_used(height_set, MAX_HEIGHT);
      if ($urandom_range(0, 99) < 8) begin
        // broken frame: part of it, then a restart through a size write
        send_pixels(style, pct, $urandom_range(1, total - 1));
        write_reg(REG_IMAGE_WIDTH, random_dim());
      end else begin
        send_frame(style, pct);
        frames_done++;
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_size();
    test_window_classes();
    test_solid_and_checker();
    test_size_extremes();
    test_restart_and_spare_index();
    test_random_frames();

    // let the last frame drain, then a quiet tail for stray results
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
